/* rtl/focc_pkg.sv */
`default_nettype none

package focc_pkg;

   localparam int unsigned HALF_BITS = 16;
   localparam int unsigned POS_BITS  = 15;
   localparam int unsigned END_BITS  = 17;

   // First byte offset of the covered range.
   localparam logic [END_BITS-1:0] RANGE_START = 17'd14;
   localparam logic [POS_BITS-1:0] POS_MAX     = 15'd32767;

   // Word positions with special handling.
   localparam logic [POS_BITS-1:0] WORD_HELD   = 15'd3;
   localparam logic [POS_BITS-1:0] WORD_LENGTH = 15'd4;

   typedef struct packed {
      logic [31:0] data_word;
      logic        first_word;
      logic        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [HALF_BITS-1:0] checksum;
      logic                 short_frame;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/focc_req_if.sv */
`default_nettype none

interface focc_req_if;
   logic                      valid;
   logic                      ready;
   focc_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/focc_rsp_if.sv */
`default_nettype none

interface focc_rsp_if;
   logic                      valid;
   logic                      ready;
   focc_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/frame_ones_complement_checksum.sv */
// Ones-complement checksum over a length-delimited byte range of an Ethernet frame.
// req_if carries one big-endian 32-bit frame word per request, with first_word
// marking word 0 and last_word the final word. The range starts at byte 14 and
// its length is the upper half of word 4.
// rsp_if carries at most one response per frame: the inverted folded sum, with
// short_frame set when the frame ended before the range was covered. Words after
// the response are dropped until the next first_word.
// The accepting edge loads the input register; the word is then processed into the
// response register, from which rsp_if takes the response.
// Throughput: one request per cycle unless the receiver stalls a full response
// register; the per-word state update is combinational from the input register.
// Reset clears the frame state (range end back to 14) and empties both
// registers. When the receiver stalls, the response register holds; the input
// register still accepts one more request, and req_if.ready falls only when
// both registers are full.
`default_nettype none

module frame_ones_complement_checksum (
   input wire logic clock,
   input wire logic reset,
   focc_req_if.sink   req_if,
   focc_rsp_if.source rsp_if
);

   localparam int unsigned PW = focc_pkg::POS_BITS;
   localparam int unsigned EW = focc_pkg::END_BITS;

   // Input register.
   logic                      s1_valid_ff, s1_valid_in;
   focc_pkg::req_payload_type s1_data_ff, s1_data_in;

   // Frame state.
   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   sum_ff, sum_in;
   logic [15:0]   held_ff, held_in;
   logic [EW-1:0] rend_ff, rend_in;
   logic          fin_ff, fin_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   focc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic          out_free, proc, skip, emit, covered;
   logic [PW-1:0] w;
   logic [31:0]   sum_cur;
   logic [15:0]   held_cur;
   logic [EW-1:0] rend_cur;
   logic [EW:0]   off;
   logic [15:0]   upper, lower, held_add;
   logic [15:0]   fold_out;

   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign proc        = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_if.ready) begin
         s1_valid_in = req_if.valid;
         s1_data_in  = req_if.payload;
      end
   end

   assign upper = s1_data_ff.data_word[31:16];
   assign lower = s1_data_ff.data_word[15:0];

   // A first word restarts the frame before the word itself is handled.
   always_comb begin
      w        = s1_data_ff.first_word ? '0 : pos_ff;
      sum_cur  = s1_data_ff.first_word ? '0 : sum_ff;
      held_cur = s1_data_ff.first_word ? '0 : held_ff;
      rend_cur = s1_data_ff.first_word ? focc_pkg::RANGE_START : rend_ff;
      skip     = !s1_data_ff.first_word && fin_ff;

      held_in  = held_cur;
      rend_in  = rend_cur;
      held_add = '0;
      if (w == focc_pkg::WORD_HELD) begin
         held_in = lower;
      end
      if (w == focc_pkg::WORD_LENGTH) begin
         rend_in = focc_pkg::RANGE_START + {1'b0, upper};
         if (upper != '0) begin
            held_add = held_cur;
         end
      end

      off    = {1'b0, w, 2'b00};
      sum_in = sum_cur + {16'd0, held_add};
      if (w >= focc_pkg::WORD_LENGTH) begin
         if (off < {1'b0, rend_in}) begin
            sum_in = sum_in + {16'd0, upper};
         end
         if (off + 18'd2 < {1'b0, rend_in}) begin
            sum_in = sum_in + {16'd0, lower};
         end
      end
      covered = (w >= focc_pkg::WORD_LENGTH) && (off + 18'd4 >= {1'b0, rend_in});
      emit    = covered || s1_data_ff.last_word;
      pos_in  = (w < focc_pkg::POS_MAX) ? w + 1'b1 : w;
      fin_in  = emit;
   end

   focc_fold u_fold (
      .sum      (sum_in),
      .checksum (fold_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = proc && !skip && emit;
         rsp_data_in.checksum    = fold_out;
         rsp_data_in.short_frame = !covered;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         held_ff      <= '0;
         rend_ff      <= focc_pkg::RANGE_START;
         fin_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proc && !skip) begin
            pos_ff  <= pos_in;
            sum_ff  <= sum_in;
            held_ff <= held_in;
            rend_ff <= rend_in;
            fin_ff  <= fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // A response closes the frame, so the finished flag is set right after it.
   a_fin_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (proc && !skip && emit) |=> fin_ff)
      else $error("finished flag not set after a response");

   // A finished frame gives no further response without a first word.
   a_no_rsp_when_fin: assert property (@(posedge clock) disable iff (reset)
      (proc && fin_ff && !s1_data_ff.first_word) |=> !$rose(rsp_valid_ff))
      else $error("response given for a finished frame");

   // Words after the response leave the sum untouched.
   a_sum_frozen: assert property (@(posedge clock) disable iff (reset)
      (proc && fin_ff && !s1_data_ff.first_word) |=> $stable(sum_ff))
      else $error("sum changed after the frame finished");

   // The range never ends before it starts.
   a_rend_min: assert property (@(posedge clock) disable iff (reset)
      rend_ff >= focc_pkg::RANGE_START)
      else $error("range end below the range start");
`endif

endmodule

`default_nettype wire

/* rtl/focc_fold.sv */
`default_nettype none

module focc_fold (
   input  wire logic [31:0]                     sum,
   output      logic [focc_pkg::HALF_BITS-1:0] checksum
);

   logic [focc_pkg::HALF_BITS:0]   first_fold;
   logic [focc_pkg::HALF_BITS-1:0] second_fold;

   // Two end-around carry folds always bring a 32-bit sum into 16 bits, which are then inverted.
   always_comb begin
      first_fold  = {1'b0, sum[31:16]} + {1'b0, sum[15:0]};
      second_fold = first_fold[15:0] + {15'd0, first_fold[16]};
      checksum    = ~second_fold;
   end

endmodule

`default_nettype wire
